FILE: design/uart_rf_pkg.sv
package uart_rf_pkg;

  typedef enum logic [1:0] {
    CMD_BUS_WRITE = 2'd0,
    CMD_BUS_READ  = 2'd1,
    CMD_LINE_RX   = 2'd2,
    CMD_LINE_TX   = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  localparam logic [2:0] REG_DATA = 3'd0;
  localparam logic [2:0] REG_IER  = 3'd1;
  localparam logic [2:0] REG_IIR  = 3'd2;
  localparam logic [2:0] REG_LCR  = 3'd3;
  localparam logic [2:0] REG_MCR  = 3'd4;
  localparam logic [2:0] REG_LSR  = 3'd5;
  localparam logic [2:0] REG_MSR  = 3'd6;
  localparam logic [2:0] REG_SCR  = 3'd7;

  localparam logic [7:0] LSR_THR_MASK = 8'h60;
  localparam logic [7:0] LSR_ERR_MASK = 8'h1E;
  localparam logic [7:0] LSR_CLR_MASK = 8'h0E;
  localparam logic [7:0] LSR_THRE     = 8'h20;
  localparam logic [7:0] LSR_OVERRUN  = 8'h02;
  localparam logic [7:0] LSR_DR       = 8'h01;
  localparam logic [7:0] LCR_DLAB     = 8'h80;
  localparam logic [7:0] MSR_CTS      = 8'h10;
  localparam logic [7:0] MSR_DCTS     = 8'h01;

  localparam logic [2:0] IIR_LINE  = 3'd6;
  localparam logic [2:0] IIR_RDA   = 3'd4;
  localparam logic [2:0] IIR_THRE  = 3'd2;
  localparam logic [2:0] IIR_NONE  = 3'd1;

endpackage

FILE: design/uart_rf_ctrl.sv
module uart_rf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output uart_rf_pkg::ctrl_cmd_t ctl
);
  import uart_rf_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    ctl            = '0;
    in_stall       = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid || !out_stall) begin
          ctl.execute    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> state == ST_EXEC)
    else $error("capture not followed by exec state");

  a_exec_loads_output: assert property (@(posedge clk) disable iff (rst)
    ctl.execute |=> out_valid)
    else $error("result not presented after execute");

  a_exec_needs_room: assert property (@(posedge clk) disable iff (rst)
    ctl.execute |-> (!out_valid || !out_stall))
    else $error("execute overwrote a pending result");

endmodule

FILE: design/uart_rf_dp.sv
module uart_rf_dp #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  uart_rf_pkg::ctrl_cmd_t ctl,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic [1:0]             command,
  input  logic [2:0]             reg_index,
  input  logic [7:0]             write_data,
  input  logic [7:0]             rx_byte,
  input  logic                   cts_line,
  output logic [7:0]             read_data,
  output logic [7:0]             tx_byte,
  output logic                   tx_valid,
  output logic                   rx_dropped,
  output logic [2:0]             int_ident,
  output logic                   dtr_out,
  output logic                   rts_out,
  output logic [15:0]            divisor_word,
  output logic [7:0]             line_control
);
  import uart_rf_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(BUFFER_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + 1'b1;
    end
  endfunction

  logic [7:0] tx_mem [BUFFER_DEPTH];
  logic [7:0] rx_mem [BUFFER_DEPTH];

  logic             empty_read_zero;
  logic [7:0]       rbr, ier, lcr, mcr, lsr, msr, scr, dll, dlm;
  logic [2:0]       iir;
  logic [PTR_W-1:0] tx_wr_ptr, tx_rd_ptr, rx_wr_ptr, rx_rd_ptr;

  cmd_t       cap_cmd;
  logic [2:0] cap_idx;
  logic [7:0] cap_wdata, cap_rx, tx_q, rx_q;
  logic       cap_cts;

  logic [7:0] rbr_next, ier_next, lcr_next, mcr_next, lsr_next, msr_next;
  logic [7:0] scr_next, dll_next, dlm_next;
  logic [2:0] iir_next;
  logic [7:0] rdata, txb, lsr_t, msr_nv;
  logic       txv, dropped, tx_push, tx_pop, rx_push, rx_pop, recompute;
  logic       tx_full, tx_full_after, tx_nonempty, rx_full, rx_nonempty, rx_more, dlab;

  assign tx_full       = ptr_inc(tx_wr_ptr) == tx_rd_ptr;
  assign tx_full_after = ptr_inc(ptr_inc(tx_wr_ptr)) == tx_rd_ptr;
  assign tx_nonempty   = tx_wr_ptr != tx_rd_ptr;
  assign rx_full       = ptr_inc(rx_wr_ptr) == rx_rd_ptr;
  assign rx_nonempty   = rx_wr_ptr != rx_rd_ptr;
  assign rx_more       = ptr_inc(rx_rd_ptr) != rx_wr_ptr;
  assign dlab          = (lcr & LCR_DLAB) != 8'h00;

  always_comb begin
    rbr_next  = rbr;
    ier_next  = ier;
    lcr_next  = lcr;
    mcr_next  = mcr;
    lsr_next  = lsr;
    msr_next  = msr;
    scr_next  = scr;
    dll_next  = dll;
    dlm_next  = dlm;
    iir_next  = iir;
    rdata     = 8'h00;
    txb       = 8'h00;
    txv       = 1'b0;
    dropped   = 1'b0;
    tx_push   = 1'b0;
    tx_pop    = 1'b0;
    rx_push   = 1'b0;
    rx_pop    = 1'b0;
    recompute = 1'b0;
    lsr_t     = lsr;
    msr_nv    = (msr & ~(MSR_CTS | MSR_DCTS)) | (cap_cts ? MSR_CTS : 8'h00);
    msr_nv    = msr_nv | (((msr ^ msr_nv) & MSR_CTS) != 8'h00 ? MSR_DCTS : 8'h00);
    case (cap_cmd)
      CMD_BUS_WRITE: begin
        if (cap_idx == REG_IIR || cap_idx == REG_LSR || cap_idx == REG_MSR) begin
          recompute = 1'b0;
        end else if (dlab && cap_idx == REG_DATA) begin
          dll_next = cap_wdata;
        end else if (dlab && cap_idx == REG_IER) begin
          dlm_next = cap_wdata;
        end else if (cap_idx == REG_DATA) begin
          lsr_t = lsr & ~LSR_THR_MASK;
          if (tx_full) begin
            lsr_t = lsr_t | LSR_OVERRUN;
          end else begin
            tx_push = 1'b1;
            if (!tx_full_after) lsr_t = lsr_t | LSR_THR_MASK;
          end
          lsr_next  = lsr_t;
          recompute = 1'b1;
        end else begin
          case (cap_idx)
            REG_IER: ier_next = cap_wdata;
            REG_LCR: lcr_next = cap_wdata;
            REG_MCR: mcr_next = cap_wdata;
            REG_SCR: scr_next = cap_wdata;
            default: scr_next = scr;
          endcase
        end
      end
      CMD_BUS_READ: begin
        if (dlab && cap_idx == REG_DATA) begin
          rdata = dll;
        end else if (dlab && cap_idx == REG_IER) begin
          rdata = dlm;
        end else begin
          case (cap_idx)
            REG_DATA: begin
              rdata = empty_read_zero ? 8'h00 : rbr;
              if (rx_nonempty) begin
                rbr_next = rx_q;
                rdata    = rx_q;
                rx_pop   = 1'b1;
              end
              lsr_next  = (lsr & ~LSR_DR) | ((rx_nonempty && rx_more) ? LSR_DR : 8'h00);
              recompute = 1'b1;
            end
            REG_IER: rdata = ier;
            REG_IIR: rdata = {5'd0, iir};
            REG_LCR: rdata = lcr;
            REG_MCR: rdata = mcr;
            REG_LSR: begin
              rdata     = lsr;
              lsr_next  = lsr & ~LSR_CLR_MASK;
              recompute = 1'b1;
            end
            REG_MSR: begin
              rdata    = msr_nv;
              msr_next = msr_nv;
            end
            REG_SCR: rdata = scr;
            default: rdata = 8'h00;
          endcase
        end
      end
      CMD_LINE_RX: begin
        lsr_t = lsr;
        if (rx_full) begin
          dropped = 1'b1;
          lsr_t   = lsr_t | LSR_OVERRUN;
        end else begin
          rx_push = 1'b1;
        end
        if (!tx_full) lsr_t = lsr_t | LSR_THR_MASK;
        lsr_next  = lsr_t | LSR_DR;
        recompute = 1'b1;
      end
      CMD_LINE_TX: begin
        if (tx_nonempty) begin
          txb    = tx_q;
          txv    = 1'b1;
          tx_pop = 1'b1;
        end
        lsr_next  = lsr | LSR_THR_MASK | (rx_nonempty ? LSR_DR : 8'h00);
        recompute = 1'b1;
      end
      default: begin
        recompute = 1'b0;
      end
    endcase
    if (recompute) begin
      msr_next = (msr_next & ~MSR_CTS)
                 | (((lsr_next & LSR_THRE) != 8'h00) ? MSR_CTS : 8'h00);
      if ((lsr_next & LSR_ERR_MASK) != 8'h00) begin
        iir_next = IIR_LINE;
      end else if ((lsr_next & LSR_DR) != 8'h00) begin
        iir_next = IIR_RDA;
      end else if ((lsr_next & LSR_THRE) != 8'h00) begin
        iir_next = IIR_THRE;
      end else begin
        iir_next = IIR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_read_zero <= 1'b0;
      rbr       <= 8'h00;
      ier       <= 8'h00;
      iir       <= 3'd0;
      lcr       <= 8'h00;
      mcr       <= 8'h00;
      lsr       <= 8'h00;
      msr       <= 8'h00;
      scr       <= 8'h00;
      dll       <= 8'h00;
      dlm       <= 8'h00;
      tx_wr_ptr <= '0;
      tx_rd_ptr <= '0;
      rx_wr_ptr <= '0;
      rx_rd_ptr <= '0;
    end else begin
      if (cfg_we) empty_read_zero <= cfg_wdata;
      if (ctl.execute) begin
        rbr <= rbr_next;
        ier <= ier_next;
        iir <= iir_next;
        lcr <= lcr_next;
        mcr <= mcr_next;
        lsr <= lsr_next;
        msr <= msr_next;
        scr <= scr_next;
        dll <= dll_next;
        dlm <= dlm_next;
        if (tx_push) tx_wr_ptr <= ptr_inc(tx_wr_ptr);
        if (tx_pop)  tx_rd_ptr <= ptr_inc(tx_rd_ptr);
        if (rx_push) rx_wr_ptr <= ptr_inc(rx_wr_ptr);
        if (rx_pop)  rx_rd_ptr <= ptr_inc(rx_rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cap_cmd   <= cmd_t'(command);
      cap_idx   <= reg_index;
      cap_wdata <= write_data;
      cap_rx    <= rx_byte;
      cap_cts   <= cts_line;
      tx_q      <= tx_mem[tx_rd_ptr];
      rx_q      <= rx_mem[rx_rd_ptr];
    end
    if (ctl.execute) begin
      read_data  <= rdata;
      tx_byte    <= txb;
      tx_valid   <= txv;
      rx_dropped <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute && tx_push) tx_mem[tx_wr_ptr] <= cap_wdata;
    if (ctl.execute && rx_push) rx_mem[rx_wr_ptr] <= cap_rx;
  end

  assign int_ident    = iir;
  assign dtr_out      = mcr[0];
  assign rts_out      = mcr[1];
  assign divisor_word = {dlm, dll};
  assign line_control = lcr;

  a_ptrs_move_on_exec: assert property (@(posedge clk) disable iff (rst)
    !ctl.execute |=> $stable(tx_wr_ptr) && $stable(tx_rd_ptr)
                     && $stable(rx_wr_ptr) && $stable(rx_rd_ptr))
    else $error("ring pointer moved outside execute");

  a_rx_overrun_flag: assert property (@(posedge clk) disable iff (rst)
    ctl.execute && cap_cmd == CMD_LINE_RX && rx_full |=> lsr[1] && rx_dropped)
    else $error("receive overrun not flagged");

  a_tx_holding_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.execute && cap_cmd == CMD_LINE_TX |=> lsr[5] && lsr[6] && iir != IIR_NONE)
    else $error("holding empty flags not set after send request");

endmodule

FILE: design/uart_register_file_with_fifos_unit.sv
// UART register file (16550 map) with transmit and receive ring buffers.
// Input channel: in_valid/in_stall carry one event per transfer: a bus write,
// a bus read, a received line byte or a line send request (command,
// reg_index, write_data, rx_byte, cts_line).
// Output channel: out_valid/out_stall carry one result per event: read_data,
// tx_byte/tx_valid, rx_dropped, and the current int_ident, dtr_out, rts_out,
// divisor_word and line_control.
// cfg_we/cfg_wdata write the empty_read_zero bit; change it only while idle.
// Each accepted event passes a capture step (registered read of the ring
// memories) and then an execute step (register update) once the output is
// free; a new event is taken only after the last one has been executed.
// While a result waits under out_stall, the next event is still taken and
// held in the execute step; in_stall stays high until the output frees up.
// Reset (rst, synchronous) clears the UART registers, empty_read_zero, out_valid
// and the ring pointers; the capture and result registers and ring contents are
// not cleared, and the rings need no clearing pass. Each ring holds up to BUFFER_DEPTH-1 bytes.
module uart_register_file_with_fifos_unit #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [2:0]  reg_index,
  input  logic [7:0]  write_data,
  input  logic [7:0]  rx_byte,
  input  logic        cts_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [7:0]  tx_byte,
  output logic        tx_valid,
  output logic        rx_dropped,
  output logic [2:0]  int_ident,
  output logic        dtr_out,
  output logic        rts_out,
  output logic [15:0] divisor_word,
  output logic [7:0]  line_control,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import uart_rf_pkg::*;

  ctrl_cmd_t ctl;

  uart_rf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  uart_rf_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .command      (command),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .rx_byte      (rx_byte),
    .cts_line     (cts_line),
    .read_data    (read_data),
    .tx_byte      (tx_byte),
    .tx_valid     (tx_valid),
    .rx_dropped   (rx_dropped),
    .int_ident    (int_ident),
    .dtr_out      (dtr_out),
    .rts_out      (rts_out),
    .divisor_word (divisor_word),
    .line_control (line_control)
  );

endmodule
